>>> design/hmf_pkg.sv
// Shared constants, types and helpers for the HTTP message framer.
`default_nettype none
package hmf_pkg;

	localparam int COUNT_WIDTH_DEF = 14;
	localparam int REG_W = 14;
	localparam int LEN_W = 15;

	localparam logic [REG_W-1:0] MAX_HDR_RST  = 14'd10240;
	localparam logic [REG_W-1:0] MAX_BODY_RST = 14'd10239;

	// Register indexes (paddr[2])
	localparam logic REG_MAX_HEADER = 1'b0;
	localparam logic REG_MAX_BODY   = 1'b1;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_HT = 8'h09;
	localparam logic [7:0] CH_VT = 8'h0B;
	localparam logic [7:0] CH_FF = 8'h0C;
	localparam logic [7:0] CH_0  = 8'h30;
	localparam logic [7:0] CH_9  = 8'h39;

	localparam logic [3:0] NAME_LAST = 4'd15;

	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_HDR_LONG  = 2'd1,
		ERR_BAD_LEN   = 2'd2,
		ERR_LEN_LIMIT = 2'd3
	} err_t;

	typedef struct packed {
		logic hdr_full;
		logic is_digit;
		logic is_blank;
		logic digit_over;
	} byte_flags_t;

	// Match one character of "\nContent-length:"; the first l may be either case.
	function automatic logic name_char_ok(input logic [3:0] pos, input logic [7:0] c);
		logic ok;
		begin
			unique case (pos)
				4'd0:  ok = (c == CH_LF);
				4'd1:  ok = (c == 8'h43);
				4'd2:  ok = (c == 8'h6F);
				4'd3:  ok = (c == 8'h6E);
				4'd4:  ok = (c == 8'h74);
				4'd5:  ok = (c == 8'h65);
				4'd6:  ok = (c == 8'h6E);
				4'd7:  ok = (c == 8'h74);
				4'd8:  ok = (c == 8'h2D);
				4'd9:  ok = (c == 8'h6C) || (c == 8'h4C);
				4'd10: ok = (c == 8'h65);
				4'd11: ok = (c == 8'h6E);
				4'd12: ok = (c == 8'h67);
				4'd13: ok = (c == 8'h74);
				4'd14: ok = (c == 8'h68);
				4'd15: ok = (c == 8'h3A);
				default: ok = 1'b0;
			endcase
			name_char_ok = ok;
		end
	endfunction

endpackage
`default_nettype wire

>>> design/http_message_framer.sv
// HTTP message framer: header terminator search, length field parse, body count.
// Each result passes through the input register and then the result register.
// Throughput: one byte per cycle when not stalled, with a single combinational pass between them.
// A full result register with out_ready low stalls the input after one more byte.
// Reset (arst_n low, asynchronous): header phase, counters and sticky error cleared,
//   limits return to 10240 header bytes and 10239 body bytes.
`default_nettype none
module http_message_framer import hmf_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire  [7:0]          data_byte,
	input  wire  [15:0]         connection_tag,
	output logic                out_valid,
	input  wire                 out_ready,
	output logic [7:0]          out_byte,
	output logic [15:0]         tag_out,
	output logic                in_header,
	output logic                end_of_message,
	output logic [LEN_W-1:0]    message_length,
	output logic [1:0]          error_code,
	input  wire                 psel,
	input  wire                 penable,
	input  wire                 pwrite,
	input  wire  [2:0]          paddr,
	input  wire  [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	localparam int CW = COUNT_WIDTH;
	localparam int VW = (CW + 4 > LEN_W) ? CW + 4 : LEN_W;
	localparam int SW = (CW + 1 > LEN_W) ? CW + 1 : LEN_W;
	localparam int HW = (CW > REG_W) ? CW : REG_W;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_VALUE,
		PH_BODY,
		PH_ERROR
	} phase_t;

	// configuration
	logic [REG_W-1:0] max_hdr_q, max_body_q;

	// message state
	phase_t          phase_q, phase_n;
	logic [1:0]      tm_q, tm_n;
	logic [3:0]      fnp_q, fnp_n;
	logic [CW-1:0]   lv_q, lv_n;
	logic            lf_q, lf_n;
	logic            ds_q, ds_n;
	logic [CW-1:0]   hc_q, hc_n;
	logic [CW-1:0]   br_q, br_n;
	err_t            sticky_q, sticky_n;

	// pipeline
	logic            v_s1, v_s2;
	logic [7:0]      byte_s1, byte_s2;
	logic [15:0]     tag_s1, tag_s2;
	logic            hdr_s2, eom_s2;
	logic [LEN_W-1:0] mlen_s2;
	err_t            err_s2;
	logic            adv;

	// per-byte combinational results
	byte_flags_t     fl;
	logic [VW-1:0]   lv_ext, prod;
	logic [CW-1:0]   hc_inc, br_dec;
	logic [SW-1:0]   sum_len, hc_inc_ext;
	logic [7:0]      term_exp;
	logic            term_done, restart;
	logic            hdr_c, eom_c;
	logic [LEN_W-1:0] mlen_c;
	err_t            err_c, newerr;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_hdr_q  <= MAX_HDR_RST;
			max_body_q <= MAX_BODY_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_MAX_HEADER: max_hdr_q  <= pwdata[REG_W-1:0];
				REG_MAX_BODY:   max_body_q <= pwdata[REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			REG_MAX_HEADER: prdata[REG_W-1:0] = max_hdr_q;
			REG_MAX_BODY:   prdata[REG_W-1:0] = max_body_q;
			default: ;
		endcase
	end

	assign adv      = v_s1 && (!v_s2 || out_ready);
	assign in_ready = !v_s1 || adv;

	assign lv_ext     = VW'(lv_q);
	assign prod       = (lv_ext << 3) + (lv_ext << 1) + VW'(byte_s1[3:0]);
	assign hc_inc     = hc_q + 1'b1;
	assign hc_inc_ext = SW'(hc_inc);
	assign br_dec     = br_q - 1'b1;
	assign sum_len    = SW'(hc_q) + SW'(lv_q);
	assign term_exp   = tm_q[0] ? CH_LF : CH_CR;

	assign fl.hdr_full   = (HW'(hc_q) >= HW'(max_hdr_q)) || (&hc_q);
	assign fl.is_digit   = (byte_s1 >= CH_0) && (byte_s1 <= CH_9);
	assign fl.is_blank   = (byte_s1 == CH_SP) || (byte_s1 == CH_HT) || (byte_s1 == CH_LF) ||
		(byte_s1 == CH_VT) || (byte_s1 == CH_FF) || (byte_s1 == CH_CR);
	assign fl.digit_over = (prod > VW'(max_body_q)) || (prod[VW-1:CW] != '0);

	always_comb begin
		phase_n   = phase_q;
		tm_n      = tm_q;
		fnp_n     = fnp_q;
		lv_n      = lv_q;
		lf_n      = lf_q;
		ds_n      = ds_q;
		hc_n      = hc_q;
		br_n      = br_q;
		sticky_n  = sticky_q;
		hdr_c     = 1'b1;
		eom_c     = 1'b0;
		mlen_c    = '0;
		err_c     = ERR_NONE;
		newerr    = ERR_NONE;
		term_done = 1'b0;
		restart   = 1'b0;
		unique case (phase_q)
			PH_ERROR: begin
				hdr_c = 1'b0;
				err_c = sticky_q;
			end
			PH_BODY: begin
				hdr_c = 1'b0;
				br_n  = br_dec;
				if (br_dec == '0) begin
					eom_c   = 1'b1;
					mlen_c  = sum_len[LEN_W-1:0];
					restart = 1'b1;
				end
			end
			PH_HEADER, PH_VALUE: begin
				if (fl.hdr_full) begin
					newerr = ERR_HDR_LONG;
				end else begin
					hc_n = hc_inc;
					if (byte_s1 == term_exp) begin
						if (tm_q == 2'd3) term_done = 1'b1;
						else tm_n = tm_q + 2'd1;
					end else begin
						tm_n = (byte_s1 == CH_CR) ? 2'd1 : 2'd0;
					end

					if (term_done) begin
						if (phase_q == PH_VALUE) begin
							newerr = ERR_BAD_LEN;
						end else if (lf_q && lv_q != '0) begin
							phase_n = PH_BODY;
							br_n    = lv_q;
							tm_n    = 2'd0;
						end else begin
							eom_c   = 1'b1;
							mlen_c  = hc_inc_ext[LEN_W-1:0];
							restart = 1'b1;
						end
					end else if (phase_q == PH_VALUE) begin
						if (fl.is_digit) begin
							ds_n = 1'b1;
							if (fl.digit_over) newerr = ERR_LEN_LIMIT;
							else lv_n = prod[CW-1:0];
						end else if (!ds_q) begin
							if (!fl.is_blank) newerr = ERR_BAD_LEN;
						end else begin
							// first non-digit closes the value
							phase_n = PH_HEADER;
						end
					end else if (!lf_q) begin
						if (name_char_ok(fnp_q, byte_s1)) begin
							if (fnp_q == NAME_LAST) begin
								lf_n    = 1'b1;
								fnp_n   = '0;
								phase_n = PH_VALUE;
							end else begin
								fnp_n = fnp_q + 4'd1;
							end
						end else begin
							fnp_n = (byte_s1 == CH_LF) ? 4'd1 : 4'd0;
						end
					end
				end
			end
			default: ;
		endcase

		if (restart) begin
			phase_n = PH_HEADER;
			tm_n    = '0;
			fnp_n   = '0;
			lv_n    = '0;
			lf_n    = 1'b0;
			ds_n    = 1'b0;
			hc_n    = '0;
			br_n    = '0;
		end

		if (newerr != ERR_NONE) begin
			sticky_n = newerr;
			phase_n  = PH_ERROR;
			err_c    = newerr;
			eom_c    = 1'b0;
			mlen_c   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			phase_q  <= PH_HEADER;
			tm_q     <= '0;
			fnp_q    <= '0;
			lv_q     <= '0;
			lf_q     <= 1'b0;
			ds_q     <= 1'b0;
			hc_q     <= '0;
			br_q     <= '0;
			sticky_q <= ERR_NONE;
		end else begin
			if (in_ready) v_s1 <= in_valid;
			if (adv) begin
				v_s2     <= 1'b1;
				phase_q  <= phase_n;
				tm_q     <= tm_n;
				fnp_q    <= fnp_n;
				lv_q     <= lv_n;
				lf_q     <= lf_n;
				ds_q     <= ds_n;
				hc_q     <= hc_n;
				br_q     <= br_n;
				sticky_q <= sticky_n;
			end else if (out_ready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
			tag_s1  <= connection_tag;
		end
		if (adv) begin
			byte_s2 <= byte_s1;
			tag_s2  <= tag_s1;
			hdr_s2  <= hdr_c;
			eom_s2  <= eom_c;
			mlen_s2 <= mlen_c;
			err_s2  <= err_c;
		end
	end

	assign out_valid      = v_s2;
	assign out_byte       = byte_s2;
	assign tag_out        = tag_s2;
	assign in_header      = hdr_s2;
	assign end_of_message = eom_s2;
	assign message_length = mlen_s2;
	assign error_code     = err_s2;

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (v_s1 && v_s2 && !out_ready))
		else $error("input stalled without a blocked result");

	a_sticky_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(sticky_q != ERR_NONE) |=> (sticky_q == $past(sticky_q)))
		else $error("sticky error changed");

	a_err_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(sticky_q != ERR_NONE) |-> (phase_q == PH_ERROR))
		else $error("sticky error outside the error phase");

	a_body_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_BODY) |-> (br_q != '0))
		else $error("body phase with nothing left to count");

	a_eom_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && end_of_message) |-> (error_code == ERR_NONE && message_length != '0))
		else $error("message end carries an error or zero length");

endmodule
`default_nettype wire

>>> dv/framing_checker.sv
// Scoreboard for the HTTP message framer: tracks register writes, predicts and compares output.
`default_nettype none
module framing_checker import hmf_pkg::*; (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	input  wire              in_ready,
	input  wire  [7:0]       data_byte,
	input  wire  [15:0]      connection_tag,
	input  wire              out_valid,
	input  wire              out_ready,
	input  wire  [7:0]       out_byte,
	input  wire  [15:0]      tag_out,
	input  wire              in_header,
	input  wire              end_of_message,
	input  wire  [LEN_W-1:0] message_length,
	input  wire  [1:0]       error_code,
	input  wire              psel,
	input  wire              penable,
	input  wire              pwrite,
	input  wire  [2:0]       paddr,
	input  wire  [31:0]      pwdata,
	input  wire              pready,
	output int               mismatches,
	output int               outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CNT_MAX = (1 << COUNT_WIDTH_DEF) - 1;
	localparam logic [8*16-1:0] FIELD_NAME = "\nContent-length:";

	typedef enum logic [1:0] {ST_HEADER, ST_VALUE, ST_BODY, ST_ERROR} frame_phase_t;

	typedef struct packed {
		logic [7:0]       data;
		logic [15:0]      tag;
		logic             hdr;
		logic             eom;
		logic [LEN_W-1:0] len;
		err_t             err;
	} framed_byte_t;

	framed_byte_t expected_bytes[$];

	logic [REG_W-1:0] hdr_limit;
	logic [REG_W-1:0] body_limit;
	logic [1:0]       crlf_seen;
	logic [4:0]       name_pos;
	frame_phase_t     state;
	int unsigned      len_val;
	bit               len_found;
	bit               got_digit;
	int unsigned      hdr_cnt;
	int unsigned      body_left;
	err_t             held_err;

	function automatic void restart();
		crlf_seen = '0;
		name_pos = '0;
		state = ST_HEADER;
		len_val = 0;
		len_found = 1'b0;
		got_digit = 1'b0;
		hdr_cnt = 0;
		body_left = 0;
	endfunction

	function automatic framed_byte_t predict_framing(input logic [7:0] c, input logic [15:0] tag);
		framed_byte_t r;
		err_t raised;
		bit closing;
		int unsigned v;
		r.data = c;
		r.tag = tag;
		r.hdr = 1'b1;
		r.eom = 1'b0;
		r.len = '0;
		r.err = ERR_NONE;
		raised = ERR_NONE;
		closing = 1'b0;
		if (state == ST_ERROR) begin
			r.hdr = 1'b0;
			r.err = held_err;
		end else if (state == ST_BODY) begin
			r.hdr = 1'b0;
			body_left = (body_left - 1) & CNT_MAX;
			if (body_left == 0) begin
				r.eom = 1'b1;
				r.len = LEN_W'(hdr_cnt + len_val);
				restart();
			end
		end else if (hdr_cnt >= hdr_limit || hdr_cnt >= CNT_MAX) begin
			raised = ERR_HDR_LONG;
		end else begin
			hdr_cnt++;
			// CR LF CR LF: even positions want CR, odd positions want LF
			if (c == (crlf_seen[0] ? CH_LF : CH_CR)) begin
				if (crlf_seen == 2'd3)
					closing = 1'b1;
				else
					crlf_seen++;
			end else begin
				crlf_seen = (c == CH_CR) ? 2'd1 : 2'd0;
			end

			if (closing) begin
				if (state == ST_VALUE) begin
					raised = ERR_BAD_LEN;
				end else if (len_found && len_val != 0) begin
					state = ST_BODY;
					body_left = len_val;
					crlf_seen = '0;
				end else begin
					r.eom = 1'b1;
					r.len = LEN_W'(hdr_cnt);
					restart();
				end
			end else if (state == ST_VALUE) begin
				if (c >= CH_0 && c <= CH_9) begin
					got_digit = 1'b1;
					v = len_val * 10 + c - CH_0;
					if (v > body_limit || v > CNT_MAX)
						raised = ERR_LEN_LIMIT;
					else
						len_val = v;
				end else if (!got_digit) begin
					if (!(c == CH_SP || c == CH_HT || c == CH_LF || c == CH_VT ||
							c == CH_FF || c == CH_CR))
						raised = ERR_BAD_LEN;
				end else begin
					// first non-digit closes the value; no further search in this header
					state = ST_HEADER;
				end
			end else if (!len_found) begin
				if (name_pos == 5'd9 ? (c == "l" || c == "L") :
						c == FIELD_NAME[8*(15 - name_pos) +: 8]) begin
					name_pos++;
					if (name_pos == 5'd16) begin
						len_found = 1'b1;
						name_pos = '0;
						state = ST_VALUE;
					end
				end else begin
					name_pos = (c == CH_LF) ? 5'd1 : 5'd0;
				end
			end
		end

		if (raised != ERR_NONE) begin
			held_err = raised;
			state = ST_ERROR;
			r.err = raised;
			r.eom = 1'b0;
			r.len = '0;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		framed_byte_t want;
		if (!arst_n) begin
			hdr_limit = MAX_HDR_RST;
			body_limit = MAX_BODY_RST;
			held_err = ERR_NONE;
			restart();
			expected_bytes.delete();
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_MAX_HEADER)
					hdr_limit = pwdata[REG_W-1:0];
				else
					body_limit = pwdata[REG_W-1:0];
			end

			// retire before predicting: a result never belongs to the same-edge transaction
			if (out_valid && out_ready) begin
				if (expected_bytes.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected output transaction: byte %02h tag %04h",
							out_byte, tag_out);
					mismatches <= mismatches + 1;
				end else begin
					want = expected_bytes.pop_front();
					if (out_byte !== want.data || tag_out !== want.tag ||
							in_header !== want.hdr || end_of_message !== want.eom ||
							message_length !== want.len || error_code !== want.err) begin
						if (mismatches < 10)
							$display({"mismatch: expected byte %02h tag %04h hdr %0b eom %0b",
								" len %0d err %0d, got byte %02h tag %04h hdr %0b eom %0b",
								" len %0d err %0d"},
								want.data, want.tag, want.hdr, want.eom, want.len, want.err,
								out_byte, tag_out, in_header, end_of_message,
								message_length, error_code);
						mismatches <= mismatches + 1;
					end
				end
			end

			if (in_valid && in_ready)
				expected_bytes.push_back(predict_framing(data_byte, connection_tag));

			outstanding <= expected_bytes.size();
		end
	end

endmodule
`default_nettype wire

>>> dv/tb_http_message_framer.sv
// Testbench top for the HTTP message framer: reset, register setup, byte stream and verdict.
`default_nettype none
module tb_http_message_framer;
	timeunit 1ns;
	timeprecision 1ps;

	import hmf_pkg::*;

	typedef enum {FAULT_HDR_LONG, FAULT_SIGN, FAULT_NO_DIGIT, FAULT_OVER_LIMIT} fault_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [7:0]       data_byte = '0;
	logic [15:0]      connection_tag = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [7:0]       out_byte;
	logic [15:0]      tag_out;
	logic             in_header;
	logic             end_of_message;
	logic [LEN_W-1:0] message_length;
	logic [1:0]       error_code;
	logic             psel = 1'b0;
	logic             penable = 1'b0;
	logic             pwrite = 1'b0;
	logic [2:0]       paddr = '0;
	logic [31:0]      pwdata = '0;
	logic [31:0]      prdata;
	logic             pready;
	int               mismatches;
	int               outstanding;

	bit               calm = 1'b0;
	int unsigned      hdr_lim = MAX_HDR_RST;
	int unsigned      body_lim = MAX_BODY_RST;
	logic [7:0]       outgoing_bytes[$];

	http_message_framer dut (.*);
	framing_checker framing_check (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) out_ready <= calm || ($urandom_range(99) >= 34);

	initial begin
		#3_000_000;
		$display("FAILURE");
		$finish;
	end

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			outgoing_bytes.push_back(s[i]);
	endfunction

	function automatic void add_noise(input int unsigned n);
		repeat (n) outgoing_bytes.push_back(8'($urandom_range(126, 33)));
	endfunction

	// Build one message; fall back to a bare terminator if the header would not fit.
	function automatic void queue_random_message();
		int unsigned mark;
		int unsigned value;
		int unsigned cap;
		mark = outgoing_bytes.size();
		value = 0;
		add_noise($urandom_range(12));
		repeat ($urandom_range(2)) begin
			add_text("\r\n");
			add_noise($urandom_range(10, 1));
		end
		if ($urandom_range(9) < 7) begin
			cap = ($urandom_range(9) == 0) ? 300 : 24;
			if (cap > body_lim)
				cap = body_lim;
			value = $urandom_range(cap);
			if ($urandom_range(1))
				add_text("\r\nContent-Length:");
			else
				add_text("\r\nContent-length:");
			repeat ($urandom_range(3)) begin
				case ($urandom_range(3))
					0: outgoing_bytes.push_back(CH_SP);
					1: outgoing_bytes.push_back(CH_HT);
					2: outgoing_bytes.push_back(CH_VT);
					default: outgoing_bytes.push_back(CH_FF);
				endcase
			end
			repeat ($urandom_range(2)) outgoing_bytes.push_back(CH_0);
			add_text($sformatf("%0d", value));
			if ($urandom_range(1))
				add_text(";q=1");
		end
		repeat ($urandom_range(2)) begin
			add_text("\r\n");
			add_noise($urandom_range(10, 1));
		end
		add_text("\r\n\r\n");
		if (outgoing_bytes.size() - mark > hdr_lim) begin
			while (outgoing_bytes.size() > mark)
				void'(outgoing_bytes.pop_back());
			add_text("\r\n\r\n");
			value = 0;
		end
		repeat (value) outgoing_bytes.push_back(8'($urandom_range(255)));
	endfunction

	task automatic send_queued(input bit fixed_tags);
		bit flip;
		flip = 1'b0;
		while (outgoing_bytes.size() != 0) begin
			// idle at random so that about a third of the cycles carry nothing
			while (!calm && $urandom_range(99) < 34) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
			in_valid <= 1'b1;
			data_byte <= outgoing_bytes.pop_front();
			connection_tag <= fixed_tags ? {16{flip}} : 16'($urandom_range(65535));
			flip = !flip;
			do @(posedge clk); while (!in_ready);
		end
	endtask

	task automatic drain();
		int unsigned guard;
		in_valid <= 1'b0;
		guard = 0;
		do begin
			@(posedge clk);
			guard++;
		end while (outstanding != 0 && guard < 5000);
	endtask

	task automatic set_limits(input logic [REG_W-1:0] hdr_max, input logic [REG_W-1:0] body_max);
		drain();
		hdr_lim = hdr_max;
		body_lim = body_max;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_MAX_HEADER, 2'b00};
		pwdata <= 32'(hdr_max);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		penable <= 1'b0;
		paddr <= {REG_MAX_BODY, 2'b00};
		pwdata <= 32'(body_max);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic run_traffic(input int unsigned quota);
		int unsigned queued;
		queued = 0;
		while (queued < quota) begin
			queue_random_message();
			queued += outgoing_bytes.size();
			send_queued(1'b0);
		end
	endtask

	initial begin : stimulus
		fault_t fault;
		int unsigned limit;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// bare terminator, data extremes in a body, odd blanks, zero length,
		// unmatched name case, repeated length line
		add_text("\r\n\r\n");
		add_text("GET / HTTP/1.1\r\nContent-Length: 3\r\n\r\n");
		outgoing_bytes.push_back(8'h00);
		outgoing_bytes.push_back(8'hFF);
		outgoing_bytes.push_back(8'h80);
		add_text("\r\nContent-length:\t");
		outgoing_bytes.push_back(CH_VT);
		outgoing_bytes.push_back(CH_FF);
		add_text("\r\n 2x\r\n\r\n");
		outgoing_bytes.push_back(8'h7F);
		outgoing_bytes.push_back(8'h01);
		add_text("\r\nContent-Length: 0\r\n\r\n");
		add_text("\r\ncontent-length: 5\r\n\r\n");
		add_text("\r\nContent-Length: 1\r\nContent-Length: 9\r\n\r\n");
		outgoing_bytes.push_back(8'hA5);
		send_queued(1'b1);

		set_limits(14'h3FFF, 14'h3FFF);
		run_traffic(600);
		set_limits(14'd4, 14'd0);
		run_traffic(100);
		set_limits(14'($urandom_range(300, 40)), 14'($urandom_range(100, 1)));
		run_traffic(500);
		calm = 1'b1;
		set_limits(14'($urandom_range(16383, 100)), 14'($urandom_range(16383, 30)));
		run_traffic(600);
		calm = 1'b0;

		// errors hold until reset, so only one kind can be raised per run
		fault = fault_t'($urandom_range(3));
		case (fault)
			FAULT_HDR_LONG: begin
				set_limits(14'd4, 14'd10);
				add_text("GET\r\n\r\n");
			end
			FAULT_SIGN: begin
				set_limits(MAX_HDR_RST, MAX_BODY_RST);
				add_text("\r\nContent-Length: -4\r\n\r\n");
			end
			FAULT_NO_DIGIT: begin
				set_limits(MAX_HDR_RST, MAX_BODY_RST);
				add_text("\r\nContent-Length:  \r\n\r\n");
			end
			default: begin
				limit = $urandom_range(1) ? 99 : 16383;
				set_limits(MAX_HDR_RST, 14'(limit));
				add_text($sformatf("\r\nContent-Length: %0d\r\n\r\n", limit + 1));
			end
		endcase
		repeat (40) outgoing_bytes.push_back(8'($urandom_range(255)));
		send_queued(1'b0);

		drain();
		repeat (4) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
`default_nettype wire
